// File: hw/rtl/fbat_pkg.sv
`default_nettype none
package fbat_pkg;

   localparam int TableDepth = 32;
   localparam int IdxW = $clog2(TableDepth);
   localparam int CntW = $clog2(TableDepth + 1);

   typedef enum logic [1:0] {
      OP_BEGIN_POLL = 2'd0,
      OP_CONNECTION = 2'd1,
      OP_PACKET     = 2'd2,
      OP_END_POLL   = 2'd3
   } op_type;

   localparam logic [19:0] MinElapsedReset = 20'd1000;
   localparam logic [19:0] UsPerS = 20'd1000000;

   // one table row as held in the entry memory
   typedef struct packed {
      logic [31:0] la;
      logic [15:0] lp;
      logic [31:0] ra;
      logic [15:0] rp;
      logic [7:0]  pr;
      logic [63:0] rx_sum;
      logic [63:0] tx_sum;
      logic [63:0] rx_prev;
      logic [63:0] tx_prev;
      logic [63:0] stamp;
   } entry_type;

   // request to the rate divider, and its answer
   typedef struct packed {
      logic        start;
      logic [63:0] delta;
      logic [63:0] dt;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quot;
   } div_rsp_type;

endpackage
`default_nettype wire

// File: hw/rtl/fbat_rate_div.sv
`default_nettype none
// floor(delta * 1e6 / dt), saturating; multiply steps D_MULL and D_MULH, then one quotient bit per cycle
module fbat_rate_div
   import fbat_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  div_req_type      req,
   output div_rsp_type      rsp
);
   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_MULL = 4'b0010,
      D_MULH = 4'b0100,
      D_DIV  = 4'b1000
   } dstate_type;

   dstate_type  st_ff, st_in;
   logic [63:0] delta_ff, delta_in, dt_ff, dt_in;
   logic [63:0] lo_ff, lo_in, rem_ff, rem_in, q_ff, q_in;
   logic [51:0] lop_ff, lop_in;
   logic [6:0]  bit_ff, bit_in;
   logic        done_ff, done_in, sat_ff, sat_in;
   logic [51:0] hip;
   logic [64:0] shl;
   logic [63:0] lo_sum;

   always_comb begin
      st_in = st_ff; delta_in = delta_ff; dt_in = dt_ff; lo_in = lo_ff;
      rem_in = rem_ff; q_in = q_ff; lop_in = lop_ff; bit_in = bit_ff;
      done_in = 1'b0; sat_in = sat_ff;
      hip = 52'(delta_ff[63:32]) * 52'(UsPerS);
      lo_sum = 64'(lop_ff) + {hip[31:0], 32'd0};
      shl = {rem_ff, lo_ff[63]};
      case (st_ff)
         D_IDLE: begin
            if (req.start) begin
               delta_in = req.delta; dt_in = req.dt; st_in = D_MULL;
            end
         end
         D_MULL: begin
            lop_in = 52'(delta_ff[31:0]) * 52'(UsPerS);
            st_in = D_MULH;
         end
         D_MULH: begin
            lo_in = lo_sum;
            rem_in = 64'(hip[51:32]) + ((lo_sum < 64'(lop_ff)) ? 64'd1 : 64'd0);
            q_in = '0; bit_in = 7'd64;
            sat_in = (64'(hip[51:32]) + ((lo_sum < 64'(lop_ff)) ? 64'd1 : 64'd0)) >= dt_ff;
            st_in = D_DIV;
         end
         D_DIV: begin
            if (sat_ff) begin
               q_in = '1; done_in = 1'b1; st_in = D_IDLE;
            end else begin
               lo_in = {lo_ff[62:0], 1'b0};
               if (shl >= {1'b0, dt_ff}) begin
                  rem_in = 64'(shl - {1'b0, dt_ff});
                  q_in = {q_ff[62:0], 1'b1};
               end else begin
                  rem_in = shl[63:0];
                  q_in = {q_ff[62:0], 1'b0};
               end
               bit_in = bit_ff - 7'd1;
               if (bit_ff == 7'd1) begin
                  done_in = 1'b1; st_in = D_IDLE;
               end
            end
         end
         default: st_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= D_IDLE; done_ff <= 1'b0;
      end else begin
         st_ff <= st_in; done_ff <= done_in;
      end
      delta_ff <= delta_in; dt_ff <= dt_in; lo_ff <= lo_in; rem_ff <= rem_in;
      q_ff <= q_in; lop_ff <= lop_in; bit_ff <= bit_in; sat_ff <= sat_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;
endmodule
`default_nettype wire

// File: hw/rtl/fbat_entry_ram.sv
`default_nettype none
module fbat_entry_ram
   import fbat_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            rd_en,
   input  wire logic [IdxW-1:0] rd_addr,
   output entry_type            rd_data,
   input  wire logic            wr_en,
   input  wire logic [IdxW-1:0] wr_addr,
   input  entry_type            wr_data
);
   entry_type mem [TableDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: hw/rtl/flow_byte_accounting_table.sv
`default_nettype none
// Channel | Direction | Handshake         | Payload
// req     | in        | req_valid/ready   | operation, addresses, ports, protocol, count, time
// rsp     | out       | rsp_valid/ready   | entry key, rates, totals, entry_valid, last_entry
// csr     | in        | csr_write         | min_elapsed_us
//
// One request at a time; begin_poll completes as it is accepted. connection and packet
// scan the table through the single read port of the entry memory, one entry at a time in
// a read step and a compare step; a packet hit adds a write-back step. end_poll skips an
// inactive entry without reading it; an active one is read, runs the shared rate divider
// twice (rx, then tx) when the elapsed time exceeds min_elapsed_us, and is written back
// compacted in the same pass. Reset is synchronous and clears the count and active marks;
// the entry memory needs no clearing. A stalled rsp holds the scan in place; a waiting
// result alone does not hold off the next request.
module flow_byte_accounting_table
   import fbat_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_addr_a,
   input  wire logic [15:0] req_port_a,
   input  wire logic [31:0] req_addr_b,
   input  wire logic [15:0] req_port_b,
   input  wire logic [7:0]  req_protocol,
   input  wire logic [15:0] req_byte_count,
   input  wire logic [63:0] req_time_us,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_local_address_out,
   output logic [15:0]      rsp_local_port_out,
   output logic [31:0]      rsp_remote_address_out,
   output logic [15:0]      rsp_remote_port_out,
   output logic [7:0]       rsp_protocol_out,
   output logic [63:0]      rsp_rx_rate,
   output logic [63:0]      rsp_tx_rate,
   output logic [63:0]      rsp_rx_total,
   output logic [63:0]      rsp_tx_total,
   output logic             rsp_entry_valid,
   output logic             rsp_last_entry,
   input  wire logic        csr_write,
   input  wire logic [19:0] csr_min_elapsed_us
);
   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_READ  = 9'b000000010,
      S_CMP   = 9'b000000100,
      S_WB    = 9'b000001000,
      S_EREAD = 9'b000010000,
      S_EWAIT = 9'b000100000,
      S_RXDIV = 9'b001000000,
      S_TXDIV = 9'b010000000,
      S_EMIT  = 9'b100000000
   } state_type;

   state_type       st_ff, st_in;
   logic [CntW-1:0] count_ff, count_in, idx_ff, idx_in, wr_k_ff, wr_k_in;
   logic [63:0]     poll_ff, poll_in;
   logic [19:0]     min_ff;
   logic [TableDepth-1:0] act_ff, act_in;
   op_type          op_ff, op_in;
   logic [31:0]     aa_ff, aa_in, ab_ff, ab_in;
   logic [15:0]     pa_ff, pa_in, pb_ff, pb_in, len_ff, len_in;
   logic [7:0]      pr_ff, pr_in;
   logic            tx_hit_ff, tx_hit_in, emitted_ff, emitted_in;
   logic [63:0]     rr_ff, rr_in, tr_ff, tr_in, dt_ff, dt_in;
   entry_type       ent_ff, ent_in;

   logic            rd_en, wr_en;
   logic [IdxW-1:0] rd_addr, wr_addr;
   entry_type       rd_data, wr_data;
   div_req_type     dreq;
   div_rsp_type     drsp;

   logic            v_ff, v_in;
   entry_type       o_ent_ff, o_ent_in;
   logic [63:0]     o_rr_ff, o_rr_in, o_tr_ff, o_tr_in;
   logic            o_valid_ff, o_valid_in, o_last_ff, o_last_in;

   logic key_eq, tx_eq, rx_eq, more_active;
   logic [CntW-1:0] nxt;

   fbat_entry_ram u_ram (
      .clock, .rd_en, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
   );
   fbat_rate_div u_div (.clock, .reset, .req(dreq), .rsp(drsp));

   always_comb begin
      key_eq = rd_data.pr == pr_ff && rd_data.lp == pa_ff && rd_data.rp == pb_ff &&
               rd_data.la == aa_ff && rd_data.ra == ab_ff;
      tx_eq = key_eq;
      rx_eq = rd_data.pr == pr_ff && rd_data.lp == pb_ff && rd_data.rp == pa_ff &&
              rd_data.la == ab_ff && rd_data.ra == aa_ff;
      nxt = idx_ff + 1'b1;
      // any active entry at or after nxt
      more_active = 1'b0;
      for (int i = 0; i < TableDepth; i++) begin
         if (CntW'(i) >= nxt && CntW'(i) < count_ff && act_ff[i]) more_active = 1'b1;
      end
   end

   always_comb begin
      st_in = st_ff; count_in = count_ff; idx_in = idx_ff; wr_k_in = wr_k_ff;
      poll_in = poll_ff; act_in = act_ff; op_in = op_ff;
      aa_in = aa_ff; ab_in = ab_ff; pa_in = pa_ff; pb_in = pb_ff; pr_in = pr_ff;
      len_in = len_ff; tx_hit_in = tx_hit_ff;
      emitted_in = emitted_ff; rr_in = rr_ff; tr_in = tr_ff; dt_in = dt_ff;
      ent_in = ent_ff;
      rd_en = 1'b0; rd_addr = idx_ff[IdxW-1:0];
      wr_en = 1'b0; wr_addr = idx_ff[IdxW-1:0]; wr_data = ent_ff;
      dreq = '0;
      v_in = v_ff; o_ent_in = o_ent_ff; o_rr_in = o_rr_ff; o_tr_in = o_tr_ff;
      o_valid_in = o_valid_ff; o_last_in = o_last_ff;
      req_ready = 1'b0;
      if (v_ff && rsp_ready) v_in = 1'b0;

      case (st_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_ready) begin
               op_in = op_type'(req_operation);
               aa_in = req_addr_a; ab_in = req_addr_b; pa_in = req_port_a;
               pb_in = req_port_b; pr_in = req_protocol; len_in = req_byte_count;
               idx_in = '0; wr_k_in = '0; emitted_in = 1'b0;
               case (op_type'(req_operation))
                  OP_BEGIN_POLL: begin
                     act_in = '0; poll_in = req_time_us;
                  end
                  OP_PACKET: begin
                     if (req_byte_count != 16'd0 && req_protocol != 8'd0)
                        st_in = S_READ;
                  end
                  OP_CONNECTION: st_in = S_READ;
                  OP_END_POLL: st_in = S_EREAD;
                  default: st_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            if (idx_ff >= count_ff) begin
               // no match
               if (op_ff == OP_CONNECTION && count_ff != CntW'(TableDepth)) begin
                  wr_en = 1'b1; wr_addr = count_ff[IdxW-1:0];
                  wr_data = '{la: aa_ff, lp: pa_ff, ra: ab_ff, rp: pb_ff, pr: pr_ff,
                              rx_sum: '0, tx_sum: '0, rx_prev: '0, tx_prev: '0,
                              stamp: poll_ff};
                  act_in[count_ff[IdxW-1:0]] = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               st_in = S_IDLE;
            end else begin
               rd_en = 1'b1; st_in = S_CMP;
            end
         end
         S_CMP: begin
            if (op_ff == OP_CONNECTION) begin
               if (key_eq) begin
                  act_in[idx_ff[IdxW-1:0]] = 1'b1; st_in = S_IDLE;
               end else begin
                  idx_in = nxt; st_in = S_READ;
               end
            end else if (act_ff[idx_ff[IdxW-1:0]] && (tx_eq || rx_eq)) begin
               ent_in = rd_data; tx_hit_in = tx_eq; st_in = S_WB;
            end else begin
               idx_in = nxt; st_in = S_READ;
            end
         end
         S_WB: begin
            wr_en = 1'b1; wr_data = ent_ff;
            if (tx_hit_ff) wr_data.tx_sum = ent_ff.tx_sum + 64'(len_ff);
            else wr_data.rx_sum = ent_ff.rx_sum + 64'(len_ff);
            st_in = S_IDLE;
         end
         S_EREAD: begin
            if (idx_ff >= count_ff) begin
               if (!emitted_ff && !v_ff) begin
                  v_in = 1'b1; o_ent_in = '0; o_rr_in = '0; o_tr_in = '0;
                  o_valid_in = 1'b0; o_last_in = 1'b1;
               end
               if (emitted_ff || !v_ff) begin
                  count_in = wr_k_ff;
                  act_in = '0;
                  for (int i = 0; i < TableDepth; i++)
                     if (CntW'(i) < wr_k_ff) act_in[i] = 1'b1;
                  st_in = S_IDLE;
               end
            end else if (!act_ff[idx_ff[IdxW-1:0]]) begin
               idx_in = nxt;
            end else begin
               rd_en = 1'b1; st_in = S_EWAIT;
            end
         end
         S_EWAIT: begin
            ent_in = rd_data;
            dt_in = (poll_ff > rd_data.stamp) ? poll_ff - rd_data.stamp : 64'd0;
            rr_in = '0; tr_in = '0;
            if (((poll_ff > rd_data.stamp) ? poll_ff - rd_data.stamp : 64'd0) >
                64'(min_ff)) begin
               dreq.start = 1'b1; dreq.delta = rd_data.rx_sum - rd_data.rx_prev;
               dreq.dt = poll_ff - rd_data.stamp;
               st_in = S_RXDIV;
            end else begin
               st_in = S_EMIT;
            end
         end
         S_RXDIV: begin
            if (drsp.done) begin
               rr_in = drsp.quot;
               dreq.start = 1'b1; dreq.delta = ent_ff.tx_sum - ent_ff.tx_prev;
               dreq.dt = dt_ff;
               st_in = S_TXDIV;
            end
         end
         S_TXDIV: begin
            if (drsp.done) begin
               tr_in = drsp.quot; st_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!v_ff || rsp_ready) begin
               v_in = 1'b1; o_ent_in = ent_ff; o_rr_in = rr_ff; o_tr_in = tr_ff;
               o_valid_in = 1'b1; o_last_in = !more_active;
               wr_en = 1'b1; wr_addr = wr_k_ff[IdxW-1:0]; wr_data = ent_ff;
               wr_data.rx_prev = ent_ff.rx_sum; wr_data.tx_prev = ent_ff.tx_sum;
               wr_data.stamp = poll_ff;
               wr_k_in = wr_k_ff + 1'b1; emitted_in = 1'b1;
               idx_in = nxt; st_in = S_EREAD;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; count_ff <= '0; poll_ff <= '0; act_ff <= '0;
         min_ff <= MinElapsedReset; v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; count_ff <= count_in; poll_ff <= poll_in; act_ff <= act_in;
         v_ff <= v_in;
         if (csr_write) min_ff <= csr_min_elapsed_us;
      end
      idx_ff <= idx_in; wr_k_ff <= wr_k_in; op_ff <= op_in; aa_ff <= aa_in;
      ab_ff <= ab_in; pa_ff <= pa_in; pb_ff <= pb_in; pr_ff <= pr_in; len_ff <= len_in;
      tx_hit_ff <= tx_hit_in; emitted_ff <= emitted_in;
      rr_ff <= rr_in; tr_ff <= tr_in; dt_ff <= dt_in; ent_ff <= ent_in;
      o_ent_ff <= o_ent_in; o_rr_ff <= o_rr_in; o_tr_ff <= o_tr_in;
      o_valid_ff <= o_valid_in; o_last_ff <= o_last_in;
   end

   assign rsp_valid = v_ff;
   assign rsp_local_address_out = o_ent_ff.la;
   assign rsp_local_port_out = o_ent_ff.lp;
   assign rsp_remote_address_out = o_ent_ff.ra;
   assign rsp_remote_port_out = o_ent_ff.rp;
   assign rsp_protocol_out = o_ent_ff.pr;
   assign rsp_rx_rate = o_rr_ff;
   assign rsp_tx_rate = o_tr_ff;
   assign rsp_rx_total = o_ent_ff.rx_sum;
   assign rsp_tx_total = o_ent_ff.tx_sum;
   assign rsp_entry_valid = o_valid_ff;
   assign rsp_last_entry = o_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TableDepth)) else $error("entry count past depth");
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> st_ff == S_IDLE) else $error("request taken while busy");
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_entry_valid) |-> rsp_last_entry) else $error("empty not last");
   a_compact: assert property (@(posedge clock) disable iff (reset)
      wr_k_ff <= idx_ff || st_ff == S_IDLE) else $error("compaction overtook scan");
endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
module tb_top
   import fbat_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NoProgressLimit = 40000;
   localparam int DrainCycles = 120;

   typedef struct {
      logic [31:0] la;
      logic [15:0] lp;
      logic [31:0] ra;
      logic [15:0] rp;
      logic [7:0]  pr;
   } flow_key_type;

   typedef struct {
      logic [31:0] la;
      logic [15:0] lp;
      logic [31:0] ra;
      logic [15:0] rp;
      logic [7:0]  pr;
      logic [63:0] rx_rate;
      logic [63:0] tx_rate;
      logic [63:0] rx_total;
      logic [63:0] tx_total;
      logic        valid;
      logic        last;
   } flow_report_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_BEGIN_POLL;
   logic [31:0] req_addr_a = '0;
   logic [15:0] req_port_a = '0;
   logic [31:0] req_addr_b = '0;
   logic [15:0] req_port_b = '0;
   logic [7:0]  req_protocol = '0;
   logic [15:0] req_byte_count = '0;
   logic [63:0] req_time_us = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_local_address_out;
   logic [15:0] rsp_local_port_out;
   logic [31:0] rsp_remote_address_out;
   logic [15:0] rsp_remote_port_out;
   logic [7:0]  rsp_protocol_out;
   logic [63:0] rsp_rx_rate;
   logic [63:0] rsp_tx_rate;
   logic [63:0] rsp_rx_total;
   logic [63:0] rsp_tx_total;
   logic        rsp_entry_valid;
   logic        rsp_last_entry;
   logic        csr_write = 0;
   logic [19:0] csr_min_elapsed_us = '0;

   flow_byte_accounting_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_addr_a(req_addr_a), .req_port_a(req_port_a),
      .req_addr_b(req_addr_b), .req_port_b(req_port_b), .req_protocol(req_protocol),
      .req_byte_count(req_byte_count), .req_time_us(req_time_us),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_local_address_out(rsp_local_address_out),
      .rsp_local_port_out(rsp_local_port_out),
      .rsp_remote_address_out(rsp_remote_address_out),
      .rsp_remote_port_out(rsp_remote_port_out),
      .rsp_protocol_out(rsp_protocol_out),
      .rsp_rx_rate(rsp_rx_rate), .rsp_tx_rate(rsp_tx_rate),
      .rsp_rx_total(rsp_rx_total), .rsp_tx_total(rsp_tx_total),
      .rsp_entry_valid(rsp_entry_valid), .rsp_last_entry(rsp_last_entry),
      .csr_write(csr_write), .csr_min_elapsed_us(csr_min_elapsed_us)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // shadow of the flow table
   flow_key_type row_key [TableDepth];
   logic        row_active [TableDepth];
   logic [63:0] row_rx [TableDepth];
   logic [63:0] row_tx [TableDepth];
   logic [63:0] row_rx_prev [TableDepth];
   logic [63:0] row_tx_prev [TableDepth];
   logic [63:0] row_stamp [TableDepth];
   int          row_count = 0;
   logic [63:0] latched_poll_time = '0;
   logic [19:0] min_elapsed = MinElapsedReset;

   flow_report_type pending_reports[$];
   int          mismatches = 0;
   int          idle_cycles = 0;

   // receiver and sender behavior
   int          ready_pct = 100;
   int          hold_off_len = 0;
   int          hold_left = 0;
   int          gap_max = 0;
   int          burst_max = 1;
   int          burst_left = 0;

   flow_key_type key_pool [40];

   function automatic logic [63:0] bytes_per_sec(logic [63:0] delta, logic [63:0] dt);
      logic [127:0] q;
      q = ({64'd0, delta} * 128'd1000000) / {64'd0, dt};
      return (q[127:64] != 0) ? {64{1'b1}} : q[63:0];
   endfunction

   function automatic bit same_key(flow_key_type a, flow_key_type b);
      return a.la == b.la && a.lp == b.lp && a.ra == b.ra && a.rp == b.rp && a.pr == b.pr;
   endfunction

   task automatic account_request(op_type op, flow_key_type k, logic [15:0] len,
                                  logic [63:0] t);
      int hit;
      int n;
      int w;
      logic [63:0] dt;
      flow_report_type r;
      flow_key_type rev;
      hit = -1;
      n = 0;
      w = 0;
      case (op)
         OP_BEGIN_POLL: begin
            for (int i = 0; i < row_count; i++) row_active[i] = 0;
            latched_poll_time = t;
         end
         OP_CONNECTION: begin
            for (int i = 0; i < row_count; i++)
               if (hit < 0 && same_key(row_key[i], k)) hit = i;
            if (hit < 0 && row_count < TableDepth) begin
               hit = row_count++;
               row_key[hit] = k;
               row_rx[hit] = 0;
               row_tx[hit] = 0;
               row_rx_prev[hit] = 0;
               row_tx_prev[hit] = 0;
               row_stamp[hit] = latched_poll_time;
            end
            if (hit >= 0) row_active[hit] = 1;
         end
         OP_PACKET: begin
            rev = '{la: k.ra, lp: k.rp, ra: k.la, rp: k.lp, pr: k.pr};
            if (len != 0 && k.pr != 0)
               for (int i = 0; i < row_count; i++) begin
                  if (hit < 0 && row_active[i] && row_key[i].pr == k.pr) begin
                     // transmit is tested first
                     if (same_key(row_key[i], k)) begin
                        row_tx[i] += len;
                        hit = i;
                     end else if (same_key(row_key[i], rev)) begin
                        row_rx[i] += len;
                        hit = i;
                     end
                  end
               end
         end
         default: begin
            for (int i = 0; i < row_count; i++) begin
               if (row_active[i]) begin
                  dt = latched_poll_time > row_stamp[i] ? latched_poll_time - row_stamp[i] : 0;
                  r = '{la: row_key[i].la, lp: row_key[i].lp, ra: row_key[i].ra,
                        rp: row_key[i].rp, pr: row_key[i].pr, rx_rate: 0, tx_rate: 0,
                        rx_total: row_rx[i], tx_total: row_tx[i], valid: 1, last: 0};
                  if (dt > {44'd0, min_elapsed}) begin
                     r.rx_rate = bytes_per_sec(row_rx[i] - row_rx_prev[i], dt);
                     r.tx_rate = bytes_per_sec(row_tx[i] - row_tx_prev[i], dt);
                  end
                  row_rx_prev[i] = row_rx[i];
                  row_tx_prev[i] = row_tx[i];
                  row_stamp[i] = latched_poll_time;
                  pending_reports.push_back(r);
                  n++;
               end
            end
            if (n == 0) begin
               r = '{default: 0};
               r.last = 1;
               pending_reports.push_back(r);
            end else begin
               pending_reports[pending_reports.size() - 1].last = 1;
            end
            // compact away inactive rows
            for (int i = 0; i < row_count; i++) begin
               if (row_active[i]) begin
                  row_key[w] = row_key[i];
                  row_active[w] = 1;
                  row_rx[w] = row_rx[i];
                  row_tx[w] = row_tx[i];
                  row_rx_prev[w] = row_rx_prev[i];
                  row_tx_prev[w] = row_tx_prev[i];
                  row_stamp[w] = row_stamp[i];
                  w++;
               end
            end
            row_count = w;
         end
      endcase
   endtask

   task automatic send_request(op_type op, flow_key_type k, logic [15:0] len,
                               logic [63:0] t);
      req_valid <= 1;
      req_operation <= op;
      req_addr_a <= k.la;
      req_port_a <= k.lp;
      req_addr_b <= k.ra;
      req_port_b <= k.rp;
      req_protocol <= k.pr;
      req_byte_count <= len;
      req_time_us <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      account_request(op, k, len, t);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, burst_max);
         if (gap_max > 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      // connection and packet scans give no report; let them finish
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_min_elapsed(logic [19:0] v);
      wait_drained();
      csr_write <= 1;
      csr_min_elapsed_us <= v;
      @(posedge clock);
      csr_write <= 0;
      min_elapsed = v;
   endtask

   function automatic flow_key_type random_key();
      flow_key_type k;
      k.la = $urandom;
      k.lp = 16'($urandom);
      k.ra = $urandom;
      k.rp = 16'($urandom);
      k.pr = 8'($urandom);
      return k;
   endfunction

   // checker
   always @(posedge clock) begin
      flow_report_type exp_r;
      flow_report_type act;
      if (!reset && rsp_valid && rsp_ready) begin
         act = '{la: rsp_local_address_out, lp: rsp_local_port_out,
                 ra: rsp_remote_address_out, rp: rsp_remote_port_out,
                 pr: rsp_protocol_out, rx_rate: rsp_rx_rate, tx_rate: rsp_tx_rate,
                 rx_total: rsp_rx_total, tx_total: rsp_tx_total,
                 valid: rsp_entry_valid, last: rsp_last_entry};
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected report: %p", act);
         end else begin
            exp_r = pending_reports.pop_front();
            if (act.la !== exp_r.la || act.lp !== exp_r.lp || act.ra !== exp_r.ra ||
                act.rp !== exp_r.rp || act.pr !== exp_r.pr ||
                act.rx_rate !== exp_r.rx_rate || act.tx_rate !== exp_r.tx_rate ||
                act.rx_total !== exp_r.rx_total || act.tx_total !== exp_r.tx_total ||
                act.valid !== exp_r.valid || act.last !== exp_r.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("report mismatch\n  expected %p\n  actual   %p", exp_r, act);
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_off_len > 0) begin
         hold_left = hold_off_len;
         hold_off_len = 0;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= NoProgressLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic test_directed();
      flow_key_type hi_key = '{la: '1, lp: '1, ra: '1, rp: '1, pr: '1};
      flow_key_type lo_key = '{la: 0, lp: 0, ra: 0, rp: 0, pr: 0};
      flow_key_type self_key = '{la: 32'h0a000001, lp: 80, ra: 32'h0a000001, rp: 80, pr: 6};
      flow_key_type hi_rev = '{la: '1, lp: '1, ra: '1, rp: '1, pr: '1};
      // report before any poll: no active row
      send_request(OP_END_POLL, lo_key, 0, 0);
      send_request(OP_BEGIN_POLL, lo_key, 0, 0);
      send_request(OP_CONNECTION, hi_key, 0, 0);
      send_request(OP_CONNECTION, lo_key, 0, 0);
      send_request(OP_CONNECTION, hi_key, 0, 0);
      send_request(OP_CONNECTION, self_key, 0, 0);
      send_request(OP_PACKET, hi_key, 16'hffff, 0);
      send_request(OP_PACKET, hi_rev, 1, 0);
      send_request(OP_PACKET, lo_key, 100, 0);
      send_request(OP_PACKET, self_key, 0, 0);
      send_request(OP_PACKET, self_key, 500, 0);
      send_request(OP_END_POLL, lo_key, 0, 0);
      send_request(OP_BEGIN_POLL, lo_key, 0, 64'd5000);
      send_request(OP_CONNECTION, self_key, 0, 0);
      send_request(OP_CONNECTION, hi_key, 0, 0);
      send_request(OP_PACKET, self_key, 1234, 0);
      send_request(OP_END_POLL, lo_key, 0, 0);
      // time going back
      send_request(OP_BEGIN_POLL, lo_key, 0, 64'd100);
      send_request(OP_CONNECTION, self_key, 0, 0);
      send_request(OP_PACKET, self_key, 77, 0);
      send_request(OP_END_POLL, lo_key, 0, 0);
      send_request(OP_BEGIN_POLL, lo_key, 0, '1);
      send_request(OP_CONNECTION, self_key, 0, 0);
      send_request(OP_END_POLL, lo_key, 0, 0);
   endtask

   task automatic test_table_full();
      flow_key_type k;
      send_request(OP_BEGIN_POLL, key_pool[0], 0, 64'd10);
      for (int i = 0; i < TableDepth + 3; i++) begin
         k = random_key();
         send_request(OP_CONNECTION, k, 0, 0);
         if (i == 2) send_request(OP_PACKET, k, 16'($urandom), 0);
      end
      send_request(OP_BEGIN_POLL, key_pool[0], 0, 64'd2000000);
      send_request(OP_END_POLL, key_pool[0], 0, 0);
   endtask

   task automatic random_poll(logic [63:0] base, int conns, int pkts);
      flow_key_type k;
      flow_key_type fk;
      send_request(OP_BEGIN_POLL, key_pool[0], 0,
                   ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : base);
      for (int i = 0; i < conns; i++)
         send_request(OP_CONNECTION, key_pool[$urandom_range(0, 39)], 0, 0);
      for (int i = 0; i < pkts; i++) begin
         k = key_pool[$urandom_range(0, 39)];
         fk = k;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5, 6: fk = '{la: k.ra, lp: k.rp, ra: k.la, rp: k.lp, pr: k.pr};
            7: fk.pr = 0;
            8: fk.la = $urandom;
            default: send_request(OP_CONNECTION, k, 0, 0);
         endcase
         send_request(OP_PACKET, fk, ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom),
                      {$urandom, $urandom});
      end
      send_request(OP_END_POLL, key_pool[0], 0, 0);
   endtask

   task automatic test_random(int polls, logic [63:0] start);
      logic [63:0] t = start;
      for (int p = 0; p < polls; p++) begin
         t += $urandom_range(0, 2500000);
         random_poll(t, $urandom_range(1, 8), $urandom_range(0, 8));
      end
   endtask

   task automatic test_backpressure();
      hold_off_len = 3000;
      gap_max = 0;
      test_random(2, 64'd50000000);
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < 40; i++) begin
         key_pool[i] = random_key();
         if (i % 8 == 0) key_pool[i].pr = 17;
      end
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      ready_pct = 100;
      test_directed();
      write_min_elapsed(20'd0);
      ready_pct = 50;
      gap_max = 4;
      burst_max = 3;
      test_table_full();
      write_min_elapsed(20'd1000000);
      test_random(4, 64'd10000000);
      write_min_elapsed(20'($urandom_range(0, 1000000)));
      ready_pct = 80;
      gap_max = 0;
      test_random(4, 64'd30000000);
      test_backpressure();
      write_min_elapsed(20'd1000);
      ready_pct = 30;
      gap_max = 6;
      burst_max = 5;
      test_random(5, 64'd80000000);

      wait_drained();
      if (mismatches == 0 && pending_reports.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire
